/* design/msm_pkg.sv */
// Shared types, constants and saturation helpers for the multitrack stereo mixer.
// No dependencies; every design file imports this package.
package msm_pkg;

    localparam int TRACK_COUNT   = 8;
    localparam int TRACK_BITS    = 3;
    localparam int SAMPLE_BITS   = 16;
    localparam int ACC_BITS      = SAMPLE_BITS + 4;
    localparam int POS_BITS      = 48;
    localparam int CHAN_BITS     = 2;
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_FRAC     = 14;
    localparam int PROD_BITS     = ACC_BITS + GAIN_BITS + 1;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(16384);
    localparam logic [GAIN_BITS-1:0] GAIN_MAX   = GAIN_BITS'(32768);

    localparam logic [CHAN_BITS-1:0] CH_MONO   = CHAN_BITS'(1);
    localparam logic [CHAN_BITS-1:0] CH_STEREO = CHAN_BITS'(2);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MASTER_GAIN = 3'd0,
        REG_LOADED_MASK = 3'd1,
        REG_SOLO_MASK   = 3'd2,
        REG_MUTE_MASK   = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [TRACK_BITS-1:0]         track_number;
        logic [POS_BITS-1:0]           timeline_position;
        logic [POS_BITS-1:0]           start_sample;
        logic [CHAN_BITS-1:0]          channel_count;
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          frame_end;
    } msm_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } msm_out_t;

    // classified item: contribution already resolved (zero when skipped)
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_add;
        logic signed [SAMPLE_BITS-1:0] right_add;
        logic                          frame_end;
    } msm_op_t;

    function automatic logic signed [ACC_BITS-1:0] sat_acc(
        input logic signed [ACC_BITS:0] v
    );
        logic signed [ACC_BITS-1:0] r;
        if (v[ACC_BITS] == v[ACC_BITS-1])
            r = v[ACC_BITS-1:0];
        else if (v[ACC_BITS])
            r = {1'b1, {(ACC_BITS-1){1'b0}}};
        else
            r = {1'b0, {(ACC_BITS-1){1'b1}}};
        return r;
    endfunction

    // floor shift by the gain fraction, then saturate to a sample
    function automatic logic signed [SAMPLE_BITS-1:0] scale_sat(
        input logic signed [PROD_BITS-1:0] p
    );
        logic signed [PROD_BITS-1:0]   s;
        logic signed [SAMPLE_BITS-1:0] r;
        s = p >>> GAIN_FRAC;
        if ((&s[PROD_BITS-1:SAMPLE_BITS-1]) || !(|s[PROD_BITS-1:SAMPLE_BITS-1]))
            r = s[SAMPLE_BITS-1:0];
        else if (s[PROD_BITS-1])
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        return r;
    endfunction

endpackage

/* design/multitrack_stereo_mixer.sv */
// Top level of the multitrack stereo mixer: front end, op queue and back end.
// Depends on msm_pkg, msm_front, msm_fifo and msm_back.
//
//  channel   handshake            payload
//  cfg       cfg_we               cfg_index, cfg_data
//  in        in_valid / in_stall  in_data (msm_in_t)
//  out       out_valid/ out_stall out_data (msm_out_t)
//
// One item per cycle sustained while out_stall is low; a frame's result passes
// through the queue, then the accumulate, multiply and saturate registers.
// Reset clears the sums, the queue and all valids; gain resets to 1.0.
// An output stall fills the three result registers, then the 4-entry queue,
// before in_stall rises.
module multitrack_stereo_mixer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [msm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [msm_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  msm_pkg::msm_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output msm_pkg::msm_out_t                 out_data
);
    import msm_pkg::*;

    logic                 push;
    msm_op_t              push_op;
    logic                 full;
    logic                 pop;
    logic                 not_empty;
    msm_op_t              pop_op;
    logic [GAIN_BITS-1:0] gain;

    msm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .push      (push),
        .push_op   (push_op),
        .full      (full),
        .gain      (gain)
    );

    msm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_op    (pop_op)
    );

    msm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .pop_op    (pop_op),
        .pop       (pop),
        .gain      (gain),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* design/msm_front.sv */
// Front end: configuration registers and per-item classification into queue ops.
// Depends on msm_pkg.
module msm_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [msm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [msm_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  msm_pkg::msm_in_t                 in_data,
    output logic                             push,
    output msm_pkg::msm_op_t                 push_op,
    input  logic                             full,
    output logic [msm_pkg::GAIN_BITS-1:0]    gain
);
    import msm_pkg::*;

    logic [GAIN_BITS-1:0]   master_gain_reg, master_gain_next;
    logic [TRACK_COUNT-1:0] loaded_mask_reg, loaded_mask_next;
    logic [TRACK_COUNT-1:0] solo_mask_reg, solo_mask_next;
    logic [TRACK_COUNT-1:0] mute_mask_reg, mute_mask_next;

    logic track_ok;
    logic any_solo;
    logic chans_ok;
    logic mono;
    logic on;

    always_comb
    begin
        master_gain_next = master_gain_reg;
        loaded_mask_next = loaded_mask_reg;
        solo_mask_next   = solo_mask_reg;
        mute_mask_next   = mute_mask_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MASTER_GAIN: master_gain_next = cfg_data[GAIN_BITS-1:0];
                REG_LOADED_MASK: loaded_mask_next = cfg_data[TRACK_COUNT-1:0];
                REG_SOLO_MASK:   solo_mask_next   = cfg_data[TRACK_COUNT-1:0];
                REG_MUTE_MASK:   mute_mask_next   = cfg_data[TRACK_COUNT-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_gain_reg <= GAIN_RESET;
            loaded_mask_reg <= '0;
            solo_mask_reg   <= '0;
            mute_mask_reg   <= '0;
        end
        else
        begin
            master_gain_reg <= master_gain_next;
            loaded_mask_reg <= loaded_mask_next;
            solo_mask_reg   <= solo_mask_next;
            mute_mask_reg   <= mute_mask_next;
        end
    end

    assign gain = (master_gain_reg > GAIN_MAX) ? GAIN_MAX : master_gain_reg;

    always_comb
    begin
        track_ok = int'(in_data.track_number) < TRACK_COUNT;
        any_solo = |solo_mask_reg;
        mono     = in_data.channel_count == CH_MONO;
        chans_ok = mono || (in_data.channel_count == CH_STEREO);
        on       = track_ok
                   && loaded_mask_reg[in_data.track_number]
                   && (!any_solo || solo_mask_reg[in_data.track_number])
                   && !mute_mask_reg[in_data.track_number]
                   && (in_data.timeline_position >= in_data.start_sample)
                   && chans_ok;
        push_op.left_add  = on ? in_data.left_sample : '0;
        push_op.right_add = on ? (mono ? in_data.left_sample : in_data.right_sample) : '0;
        push_op.frame_end = in_data.frame_end;
    end

    assign in_stall = full;
    assign push     = in_valid && !full;

endmodule

/* design/msm_fifo.sv */
// Short queue of classified ops between the front end and the mixing back end.
// Depends on msm_pkg.
module msm_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  msm_pkg::msm_op_t push_op,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output msm_pkg::msm_op_t pop_op
);
    import msm_pkg::*;

    msm_op_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_op;
    end

    assign full      = count_reg == FIFO_CNT_BITS'(FIFO_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_op    = mem[rd_ptr_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

/* design/msm_back.sv */
// Back end: saturating accumulation, master gain multiply, floor and saturate.
// Depends on msm_pkg.
module msm_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          not_empty,
    input  msm_pkg::msm_op_t              pop_op,
    output logic                          pop,
    input  logic [msm_pkg::GAIN_BITS-1:0] gain,
    output logic                          out_valid,
    input  logic                          out_stall,
    output msm_pkg::msm_out_t             out_data
);
    import msm_pkg::*;

    logic signed [ACC_BITS-1:0]  left_sum_reg, left_sum_next;
    logic signed [ACC_BITS-1:0]  right_sum_reg, right_sum_next;
    logic signed [ACC_BITS-1:0]  left_tot, right_tot;

    logic                        mul_valid_reg, mul_valid_next;
    logic signed [ACC_BITS-1:0]  mul_l_reg, mul_r_reg;
    logic                        prod_valid_reg, prod_valid_next;
    logic signed [PROD_BITS-1:0] prod_l_reg, prod_r_reg;
    logic                        out_valid_reg, out_valid_next;
    msm_out_t                    out_data_reg;

    logic out_ready;
    logic prod_ready;
    logic mul_ready;
    logic signed [GAIN_BITS:0] gain_s;

    assign out_ready  = !out_valid_reg || !out_stall;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign mul_ready  = !mul_valid_reg || prod_ready;
    assign pop        = not_empty && mul_ready;
    assign gain_s     = $signed({1'b0, gain});

    always_comb
    begin
        left_tot  = sat_acc((ACC_BITS+1)'(left_sum_reg) + (ACC_BITS+1)'(pop_op.left_add));
        right_tot = sat_acc((ACC_BITS+1)'(right_sum_reg) + (ACC_BITS+1)'(pop_op.right_add));
        left_sum_next  = left_sum_reg;
        right_sum_next = right_sum_reg;
        if (pop)
        begin
            left_sum_next  = pop_op.frame_end ? '0 : left_tot;
            right_sum_next = pop_op.frame_end ? '0 : right_tot;
        end
        mul_valid_next  = pop ? pop_op.frame_end : (mul_valid_reg && !prod_ready);
        prod_valid_next = prod_ready ? mul_valid_reg : prod_valid_reg;
        out_valid_next  = out_ready ? prod_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_sum_reg   <= '0;
            right_sum_reg  <= '0;
            mul_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            left_sum_reg   <= left_sum_next;
            right_sum_reg  <= right_sum_next;
            mul_valid_reg  <= mul_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_op.frame_end)
        begin
            mul_l_reg <= left_tot;
            mul_r_reg <= right_tot;
        end
        if (prod_ready && mul_valid_reg)
        begin
            prod_l_reg <= PROD_BITS'(mul_l_reg) * PROD_BITS'(gain_s);
            prod_r_reg <= PROD_BITS'(mul_r_reg) * PROD_BITS'(gain_s);
        end
        if (out_ready && prod_valid_reg)
        begin
            out_data_reg.left_out  <= scale_sat(prod_l_reg);
            out_data_reg.right_out <= scale_sat(prod_r_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_op.frame_end) |=> (left_sum_reg == '0 && right_sum_reg == '0))
        else $error("accumulators not cleared after frame end");

    a_mul_held: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_valid_reg && !prod_ready) |=> (mul_valid_reg && $stable(mul_l_reg)))
        else $error("multiplier input lost while stalled");

    a_out_from_prod: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(prod_valid_reg))
        else $error("result appeared without a product");

endmodule

/* test/tb_multitrack_stereo_mixer.sv */
// Self-checking bench for multitrack_stereo_mixer: directed frames, random traffic, stalls.
// Predicts each mixed frame and compares it with every output transfer.
// Depends on msm_pkg and the multitrack_stereo_mixer RTL.
module tb_multitrack_stereo_mixer;
    timeunit 1ns;
    timeprecision 1ps;

    import msm_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_LEN   = 11;
    localparam int REG_COUNT   = REG_MUTE_MASK + 1;
    localparam int QUIET_LEN   = 12;
    localparam int HOLD_CYCLES = 400;

    localparam logic [CHAN_BITS-1:0] CH_SKIP_LOW  = CHAN_BITS'(0);
    localparam logic [CHAN_BITS-1:0] CH_SKIP_HIGH = CHAN_BITS'(3);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [POS_BITS-1:0]           POS_TOP    = {POS_BITS{1'b1}};

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    msm_in_t                  in_data   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    msm_out_t                 out_data;

    // predictor state
    logic [GAIN_BITS-1:0]   gain_reg;
    logic [TRACK_COUNT-1:0] loaded_reg;
    logic [TRACK_COUNT-1:0] solo_reg;
    logic [TRACK_COUNT-1:0] mute_reg;
    longint                 left_acc;
    longint                 right_acc;
    msm_out_t               mixed_frames[$];

    int       errors        = 0;
    int       items_sent    = 0;
    int       send_idle_pct = 0;
    int       stall_pct     = 0;
    int       hold_requests = 0;
    int       hold_served   = 0;
    int       hold_left     = 0;
    msm_out_t want;

    multitrack_stereo_mixer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic longint clamp_to(input longint v, input int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] apply_gain(input longint acc);
        longint g;
        g = (gain_reg > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(gain_reg);
        return SAMPLE_BITS'(clamp_to((acc * g) >>> GAIN_FRAC, SAMPLE_BITS));
    endfunction

    function automatic void store_reg(input cfg_reg_t id, input logic [CFG_DATA_BITS-1:0] v);
        case (id)
            REG_MASTER_GAIN: gain_reg   = v;
            REG_LOADED_MASK: loaded_reg = v[TRACK_COUNT-1:0];
            REG_SOLO_MASK:   solo_reg   = v[TRACK_COUNT-1:0];
            REG_MUTE_MASK:   mute_reg   = v[TRACK_COUNT-1:0];
            default: ;
        endcase
    endfunction

    function automatic void mix_track_sample(input msm_in_t it);
        logic     plays;
        longint   ls;
        longint   rs;
        msm_out_t frame;
        ls = longint'(signed'(it.left_sample));
        rs = longint'(signed'(it.right_sample));
        plays = loaded_reg[it.track_number]
                && (solo_reg == '0 || solo_reg[it.track_number])
                && !mute_reg[it.track_number]
                && it.timeline_position >= it.start_sample
                && (it.channel_count == CH_MONO || it.channel_count == CH_STEREO);
        if (plays)
        begin
            left_acc  = clamp_to(left_acc + ls, ACC_BITS);
            right_acc = clamp_to(right_acc + ((it.channel_count == CH_MONO) ? ls : rs), ACC_BITS);
        end
        if (it.frame_end)
        begin
            frame.left_out  = apply_gain(left_acc);
            frame.right_out = apply_gain(right_acc);
            mixed_frames.insert(mixed_frames.size(), frame);
            left_acc  = 0;
            right_acc = 0;
        end
    endfunction

    function automatic msm_in_t make_item(
        input logic [TRACK_BITS-1:0]         track,
        input logic [POS_BITS-1:0]           pos,
        input logic [POS_BITS-1:0]           start,
        input logic [CHAN_BITS-1:0]          chans,
        input logic signed [SAMPLE_BITS-1:0] l,
        input logic signed [SAMPLE_BITS-1:0] r,
        input logic                          last
    );
        msm_in_t it;
        it.track_number      = track;
        it.timeline_position = pos;
        it.start_sample      = start;
        it.channel_count     = chans;
        it.left_sample       = l;
        it.right_sample      = r;
        it.frame_end         = last;
        return it;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7, 0))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // valid stays high across back-to-back transfers
    task automatic send_item(input msm_in_t it);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        mix_track_sample(it);
        items_sent++;
    endtask

    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        while (mixed_frames.size() != 0)
            @(posedge clk);
        repeat (QUIET_LEN) @(posedge clk);
    endtask

    // writes every register, then one unused index with junk data
    task automatic set_config(
        input logic [CFG_DATA_BITS-1:0] gain,
        input logic [CFG_DATA_BITS-1:0] loaded,
        input logic [CFG_DATA_BITS-1:0] solo,
        input logic [CFG_DATA_BITS-1:0] mute
    );
        logic [CFG_DATA_BITS-1:0] vals[REG_COUNT];
        cfg_reg_t                 id;
        wait_for_quiet();
        vals = '{gain, loaded, solo, mute};
        id = REG_MASTER_GAIN;
        repeat (REG_COUNT)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= id;
            cfg_data  <= vals[id];
            @(posedge clk);
            store_reg(id, vals[id]);
            id = id.next();
        end
        cfg_index <= CFG_IDX_BITS'($urandom_range(2 ** CFG_IDX_BITS - 1, REG_COUNT));
        cfg_data  <= CFG_DATA_BITS'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic randomise_config();
        logic [CFG_DATA_BITS-1:0] gain;
        logic [CFG_DATA_BITS-1:0] solo;
        case ($urandom_range(5, 0))
            0:       gain = '0;
            1:       gain = GAIN_MAX;
            2:       gain = CFG_DATA_BITS'($urandom_range(2 ** GAIN_BITS - 1, GAIN_MAX + 1));
            3:       gain = GAIN_RESET;
            default: gain = CFG_DATA_BITS'($urandom_range(GAIN_MAX, 0));
        endcase
        solo = ($urandom_range(1, 0) == 0) ? CFG_DATA_BITS'($urandom & 32'hFF00)
                                           : CFG_DATA_BITS'($urandom & $urandom);
        set_config(gain, CFG_DATA_BITS'($urandom | $urandom), solo,
                   CFG_DATA_BITS'($urandom & $urandom));
    endtask

    task automatic send_random_frame();
        msm_in_t                       it;
        logic [POS_BITS-1:0]           pos;
        logic [TRACK_BITS-1:0]         track;
        logic signed [SAMPLE_BITS-1:0] l;
        logic signed [SAMPLE_BITS-1:0] r;
        logic [159:0]                  raw;
        int                            kind;
        int                            n;
        kind = $urandom_range(99, 0);
        pos  = {16'($urandom), $urandom};
        if (kind < 80)
        begin
            n = $urandom_range(TRACK_COUNT, 1);
            for (int k = 0; k < n; k++)
            begin
                it = make_item(TRACK_BITS'($urandom), pos, '0,
                               ($urandom_range(1, 0) != 0) ? CH_MONO : CH_STEREO,
                               pick_sample(), pick_sample(), k == n - 1);
                if ($urandom_range(9, 0) == 0)
                    it.channel_count = CHAN_BITS'($urandom);
                case ($urandom_range(9, 0))
                    0:       it.start_sample = pos + POS_BITS'($urandom_range(1000, 1));
                    1:       it.start_sample = pos;
                    2:       it.start_sample = {16'($urandom), $urandom};
                    default: it.start_sample = pos - POS_BITS'($urandom_range(5000, 0));
                endcase
                send_item(it);
            end
        end
        else if (kind < 90)
        begin
            // long run of loud samples on one track can drive the sums into saturation
            n     = $urandom_range(24, 18);
            track = TRACK_BITS'($urandom);
            for (int k = 0; k < n; k++)
            begin
                l = SAMPLE_BITS'($urandom_range(32767, 24000));
                r = SAMPLE_BITS'($urandom_range(32767, 24000));
                if (kind < 85)
                begin
                    l = -l - 1;
                    r = -r - 1;
                end
                send_item(make_item(track, pos, '0, CH_STEREO, l, r, k == n - 1));
            end
        end
        else
        begin
            n = $urandom_range(6, 1);
            repeat (n)
            begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
                it  = raw[$bits(msm_in_t)-1:0];
                send_item(it);
            end
        end
    endtask

    task automatic test_mix_rules();
        logic [POS_BITS-1:0] pos;
        pos = {16'h0000, 32'h0001_0000};
        // reset state: nothing loaded, frame comes out silent
        send_item(make_item(3'd0, pos, '0, CH_MONO, 16'sd1234, 16'sd0, 1'b1));
        set_config(GAIN_RESET, 16'h00FF, 16'h0000, 16'h0080);
        send_item(make_item(3'd0, pos, '0, CH_MONO, 16'sd1000, 16'sd0, 1'b0));
        send_item(make_item(3'd1, pos, pos - 1, CH_STEREO, -16'sd500, 16'sd700, 1'b0));
        send_item(make_item(3'd2, pos, '0, CH_SKIP_LOW, 16'sd3000, 16'sd3000, 1'b0));
        send_item(make_item(3'd3, pos, '0, CH_SKIP_HIGH, 16'sd3000, 16'sd3000, 1'b0));
        send_item(make_item(3'd4, pos, pos + 1, CH_MONO, 16'sd3000, 16'sd3000, 1'b0));
        send_item(make_item(3'd5, pos, pos, CH_STEREO, 16'sd1, 16'sd2, 1'b0));
        send_item(make_item(3'd7, pos, '0, CH_MONO, 16'sd3000, 16'sd3000, 1'b1));
        send_item(make_item(3'd6, POS_TOP, '0, CH_MONO, SAMPLE_MIN, SAMPLE_MAX, 1'b0));
        send_item(make_item(3'd0, '0, '0, CH_STEREO, SAMPLE_MAX, SAMPLE_MIN, 1'b1));
        // solo on track 1, upper tracks unloaded
        set_config(GAIN_RESET, 16'hFF0F, 16'h0002, 16'h0000);
        send_item(make_item(3'd0, pos, '0, CH_MONO, 16'sd900, 16'sd0, 1'b0));
        send_item(make_item(3'd1, pos, '0, CH_STEREO, 16'sd111, -16'sd222, 1'b0));
        send_item(make_item(3'd5, pos, '0, CH_MONO, 16'sd900, 16'sd0, 1'b1));
    endtask

    task automatic test_gain_and_full_scale();
        set_config(GAIN_MAX, 16'h00FF, 16'h0000, 16'h0000);
        send_item(make_item(3'd0, '0, '0, CH_MONO, SAMPLE_MAX, 16'sd0, 1'b1));
        send_item(make_item(3'd0, '0, '0, CH_MONO, SAMPLE_MIN, 16'sd0, 1'b1));
        set_config(16'hFFFF, 16'h00FF, 16'h0000, 16'h0000);
        send_item(make_item(3'd3, '0, '0, CH_STEREO, 16'sd20000, -16'sd20000, 1'b1));
        // half gain: odd samples show the floor
        set_config(16'd8192, 16'h00FF, 16'h0000, 16'h0000);
        send_item(make_item(3'd2, '0, '0, CH_STEREO, -16'sd1, 16'sd1, 1'b1));
        send_item(make_item(3'd2, '0, '0, CH_SKIP_LOW, SAMPLE_MAX, SAMPLE_MAX, 1'b1));
        set_config(16'd0, 16'h00FF, 16'h0000, 16'h0000);
        send_item(make_item(3'd0, '0, '0, CH_MONO, SAMPLE_MAX, 16'sd0, 1'b1));
    endtask

    task automatic test_accumulator_overflow();
        set_config(16'd256, 16'h00FF, 16'h0000, 16'h0000);
        repeat (17) send_item(make_item(3'd2, '0, '0, CH_STEREO, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
        send_item(make_item(3'd2, '0, '0, CH_STEREO, SAMPLE_MIN, SAMPLE_MAX, 1'b1));
    endtask

    task automatic test_traffic(input int sender_idle, input int receiver_stall, input int count);
        int target;
        int block_end;
        send_idle_pct = sender_idle;
        stall_pct     = receiver_stall;
        target        = items_sent + count;
        while (items_sent < target)
        begin
            randomise_config();
            block_end = items_sent + 120;
            while (items_sent < block_end && items_sent < target)
                send_random_frame();
        end
    endtask

    task automatic test_output_holdoff();
        int target;
        send_idle_pct = 0;
        stall_pct     = 0;
        randomise_config();
        set_config(GAIN_RESET, 16'h00FF, 16'h0000, 16'h0000);
        hold_requests++;
        target = items_sent + 80;
        while (items_sent < target)
            send_random_frame();
    endtask

    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (mixed_frames.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual L=%0d R=%0d",
                         $time, out_data.left_out, out_data.right_out);
                errors++;
            end
            else
            begin
                want = mixed_frames.pop_front();
                if (out_data.left_out !== want.left_out)
                begin
                    $display("%0t: left_out expected %0d actual %0d",
                             $time, want.left_out, out_data.left_out);
                    errors++;
                end
                if (out_data.right_out !== want.right_out)
                begin
                    $display("%0t: right_out expected %0d actual %0d",
                             $time, want.right_out, out_data.right_out);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        gain_reg   = GAIN_RESET;
        loaded_reg = '0;
        solo_reg   = '0;
        mute_reg   = '0;
        left_acc   = 0;
        right_acc  = 0;
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_mix_rules();
        test_gain_and_full_scale();
        test_accumulator_overflow();
        test_traffic(0, 0, 400);
        test_traffic(76, 0, 400);
        test_traffic(0, 76, 400);
        test_traffic(36, 36, 400);
        test_output_holdoff();
        wait_for_quiet();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
